/* hdl/fmsk_pkg.sv */
// ----------------------------------------------------------------------------
// fmsk_pkg
// Shared constants and elaboration-time helpers for the sketch estimator:
// fixed-point format of the estimate and the exp2 scale table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package fmsk_pkg;

   localparam int COPIES_DEF    = 10;
   localparam int MASK_BITS_DEF = 32;

   localparam int FRAC_BITS = 24;   // fraction of the mean, Q0.24
   localparam int WBITS     = 30;   // exp2 product, Q2.30
   localparam int SCALE_LO  = 44;   // shift from Q.60 product down to Q.16
   localparam int EST_W     = 50;   // UQ34.16 estimate
   localparam int VAL_W     = 62;   // width of 2^frac * (1/0.77351), Q.60
   localparam int SHIFT_W   = VAL_W + 64;

   localparam logic [63:0] INV_COEF = ((64'd1 << WBITS) * 64'd100000) / 64'd77351;

   // floor integer square root, one result bit per step
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem_v;
      logic [63:0] res_v;
      logic [63:0] bit_v;
      int          i;
      rem_v = x;
      res_v = '0;
      for (i = 0; i < 32; i++) begin
         bit_v = 64'd1 << (62 - 2 * i);
         if (rem_v >= res_v + bit_v) begin
            rem_v = rem_v - (res_v + bit_v);
            res_v = (res_v >> 1) + bit_v;
         end else begin
            res_v = res_v >> 1;
         end
      end
      return res_v;
   endfunction

   // 2^f (f in Q0.24) times 1/0.77351, result in Q.60; used for constants only
   function automatic logic [63:0] frac_scale(input logic [FRAC_BITS-1:0] f);
      logic [63:0] p_v;
      logic [63:0] t_v;
      int          k;
      p_v = 64'd1 << WBITS;
      t_v = isqrt64(64'd1 << (2 * WBITS + 1));
      for (k = 1; k <= FRAC_BITS; k++) begin
         if (f[FRAC_BITS-k]) begin
            p_v = (p_v * t_v) >> WBITS;
         end
         t_v = isqrt64(t_v << WBITS);
      end
      return p_v * INV_COEF;
   endfunction

endpackage

`default_nettype wire

/* hdl/fm_sketch_merge_estimate.sv */
// ----------------------------------------------------------------------------
// fm_sketch_merge_estimate
// Distinct-count sketch unit: ORs incoming masks into COPIES stored sketch
// masks, and on the last mask of a group returns 2^(mean R)/0.77351 in
// UQ34.16 and clears the store.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  copy_index, mask_bits, group_last
//   rsp      out        rsp_valid/rsp_ready  merged_mask, estimate, estimate_valid
//
// One item per cycle sustained while rsp_ready holds; each result reaches the
// outputs through six register stages (zero positions, partial sums, sum,
// reciprocal quotient, remainder fix, table exp2 and shift).
// The mask store updates at the transfer itself, so items follow back to back.
// Reset clears the store and every stage valid. A stalled output holds every
// full stage while empty ones still fill; the input stalls once all are full.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_sketch_merge_estimate
   import fmsk_pkg::*;
#(
   parameter int COPIES    = COPIES_DEF,
   parameter int MASK_BITS = MASK_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_copy_index,
   input  wire logic [31:0] req_mask_bits,
   input  wire logic        req_group_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_merged_mask,
   output logic [EST_W-1:0] rsp_estimate,
   output logic             rsp_estimate_valid
);

   localparam int RW       = $clog2(MASK_BITS + 1);
   localparam int SW       = $clog2(COPIES * MASK_BITS + 1);
   localparam int RDW      = (COPIES > 1) ? $clog2(COPIES) : 1;
   localparam int NG       = (COPIES + 7) / 8;
   localparam int RCW      = SW + 2;
   localparam int RECIP_SH = SW + 1;
   localparam int DW       = SW + 7;
   localparam logic [RCW-1:0] RECIP = RCW'((64'd1 << RECIP_SH) / COPIES);
   localparam logic [EST_W-1:0] EST_MAX = '1;

   // ---------------------------------------------------------------- store
   logic [MASK_BITS-1:0] mask_ff  [COPIES];
   logic [MASK_BITS-1:0] mask_nxt [COPIES];
   logic [MASK_BITS-1:0] bits_w;
   logic [63:0]          bits64;
   logic [MASK_BITS-1:0] merged_w;
   logic [63:0]          merged64;
   logic [RW-1:0]        zpos     [COPIES];
   logic                 req_xfer;

   assign req_xfer = req_valid && req_ready;
   assign bits64   = 64'(req_mask_bits);
   assign bits_w   = bits64[MASK_BITS-1:0];

   always_comb begin
      merged_w = '0;
      for (int i = 0; i < COPIES; i++) begin
         if ({3'b000, req_copy_index} == 7'(i)) begin
            mask_nxt[i] = mask_ff[i] | bits_w;
            merged_w    = merged_w | mask_nxt[i];
         end else begin
            mask_nxt[i] = mask_ff[i];
         end
      end
   end

   assign merged64 = 64'(merged_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COPIES; i++) begin
            mask_ff[i] <= '0;
         end
      end else if (req_xfer) begin
         for (int i = 0; i < COPIES; i++) begin
            mask_ff[i] <= req_group_last ? '0 : mask_nxt[i];
         end
      end
   end

   for (genvar g = 0; g < COPIES; g++) begin : g_zpos
      fmsk_zero_pos #(
         .WIDTH (MASK_BITS),
         .POS_W (RW)
      ) u_zero_pos (
         .mask (mask_nxt[g]),
         .pos  (zpos[g])
      );
   end

   // exp2 of each possible fraction of the mean, times 1/0.77351
   logic [VAL_W-1:0] vtab [COPIES];
   for (genvar r = 0; r < COPIES; r++) begin : g_vtab
      localparam logic [FRAC_BITS-1:0] FR = FRAC_BITS'((64'(r) << FRAC_BITS) / COPIES);
      localparam logic [63:0] VR64 = frac_scale(FR);
      assign vtab[r] = VR64[VAL_W-1:0];
   end

   // ------------------------------------------------------------- pipeline
   logic a_valid_ff, p_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic a_rdy, p_rdy, b_rdy, c_rdy, d_rdy, e_rdy;

   assign e_rdy     = !e_valid_ff || rsp_ready;
   assign d_rdy     = !d_valid_ff || e_rdy;
   assign c_rdy     = !c_valid_ff || d_rdy;
   assign b_rdy     = !b_valid_ff || c_rdy;
   assign p_rdy     = !p_valid_ff || b_rdy;
   assign a_rdy     = !a_valid_ff || p_rdy;
   assign req_ready = a_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (a_rdy) a_valid_ff <= req_valid;
         if (p_rdy) p_valid_ff <= a_valid_ff;
         if (b_rdy) b_valid_ff <= p_valid_ff;
         if (c_rdy) c_valid_ff <= b_valid_ff;
         if (d_rdy) d_valid_ff <= c_valid_ff;
         if (e_rdy) e_valid_ff <= d_valid_ff;
      end
   end

   // stage a: zero positions of the merged masks
   logic [31:0]   a_merged_ff;
   logic          a_last_ff;
   logic [RW-1:0] a_zpos_ff [COPIES];

   always_ff @(posedge clock) begin
      if (a_rdy) begin
         a_merged_ff <= merged64[31:0];
         a_last_ff   <= req_group_last;
         for (int i = 0; i < COPIES; i++) begin
            a_zpos_ff[i] <= zpos[i];
         end
      end
   end

   // stage p: sums over groups of eight copies
   logic [31:0]   p_merged_ff;
   logic          p_last_ff;
   logic [SW-1:0] p_part_in [NG];
   logic [SW-1:0] p_part_ff [NG];

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         p_part_in[g] = '0;
         for (int j = 0; j < 8; j++) begin
            if (g * 8 + j < COPIES) begin
               p_part_in[g] = p_part_in[g] + SW'(a_zpos_ff[g * 8 + j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_rdy) begin
         p_merged_ff <= a_merged_ff;
         p_last_ff   <= a_last_ff;
         p_part_ff   <= p_part_in;
      end
   end

   // stage b: total of the zero positions
   logic [31:0]   b_merged_ff;
   logic          b_last_ff;
   logic [SW-1:0] b_sum_in;
   logic [SW-1:0] b_sum_ff;

   always_comb begin
      b_sum_in = '0;
      for (int g = 0; g < NG; g++) begin
         b_sum_in = b_sum_in + p_part_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (b_rdy) begin
         b_merged_ff <= p_merged_ff;
         b_last_ff   <= p_last_ff;
         b_sum_ff    <= b_sum_in;
      end
   end

   // stage c: quotient by reciprocal, low by at most one
   logic [31:0]       c_merged_ff;
   logic              c_last_ff;
   logic [SW-1:0]     c_sum_ff;
   logic [SW-1:0]     c_quot_ff;
   logic [SW+RCW-1:0] c_prod;

   assign c_prod = (SW+RCW)'(b_sum_ff) * (SW+RCW)'(RECIP);

   always_ff @(posedge clock) begin
      if (c_rdy) begin
         c_merged_ff <= b_merged_ff;
         c_last_ff   <= b_last_ff;
         c_sum_ff    <= b_sum_ff;
         c_quot_ff   <= c_prod[RECIP_SH +: SW];
      end
   end

   // stage d: remainder and one correction step
   logic [31:0]    d_merged_ff;
   logic           d_last_ff;
   logic [RW-1:0]  d_quot_ff;
   logic [RDW-1:0] d_rem_ff;
   logic [DW-1:0]  d_back;
   logic [DW-1:0]  d_rem0;
   logic [DW-1:0]  d_rem1;
   logic [SW-1:0]  d_quot1;
   logic           d_fix;

   assign d_back  = DW'(c_quot_ff) * DW'(COPIES);
   assign d_rem0  = DW'(c_sum_ff) - d_back;
   assign d_fix   = d_rem0 >= DW'(COPIES);
   assign d_rem1  = d_fix ? d_rem0 - DW'(COPIES) : d_rem0;
   assign d_quot1 = d_fix ? c_quot_ff + 1'b1 : c_quot_ff;

   always_ff @(posedge clock) begin
      if (d_rdy) begin
         d_merged_ff <= c_merged_ff;
         d_last_ff   <= c_last_ff;
         d_quot_ff   <= d_quot1[RW-1:0];
         d_rem_ff    <= d_rem1[RDW-1:0];
      end
   end

   // stage e: exp2 of the fraction, shift by the integer part, saturate; zero unless group last
   logic [VAL_W-1:0]   e_val;
   logic [SHIFT_W-1:0] e_shift;
   logic [EST_W-1:0]   e_est;

   assign e_val   = vtab[d_rem_ff];
   assign e_shift = SHIFT_W'(e_val) << d_quot_ff;

   always_comb begin
      if (!d_last_ff) begin
         e_est = '0;
      end else if (|e_shift[SHIFT_W-1:SCALE_LO+EST_W]) begin
         e_est = EST_MAX;
      end else begin
         e_est = e_shift[SCALE_LO +: EST_W];
      end
   end

   logic [31:0]      e_merged_ff;
   logic [EST_W-1:0] e_est_ff;
   logic             e_last_ff;

   always_ff @(posedge clock) begin
      if (e_rdy) begin
         e_merged_ff <= d_merged_ff;
         e_est_ff    <= e_est;
         e_last_ff   <= d_last_ff;
      end
   end

   assign rsp_valid          = e_valid_ff;
   assign rsp_merged_mask    = e_merged_ff;
   assign rsp_estimate       = e_est_ff;
   assign rsp_estimate_valid = e_last_ff;

endmodule

`default_nettype wire

/* hdl/fmsk_zero_pos.sv */
// ----------------------------------------------------------------------------
// fmsk_zero_pos
// Priority encoder: position of the lowest zero bit of a mask, or WIDTH
// when every bit is set.
// ----------------------------------------------------------------------------
`default_nettype none

module fmsk_zero_pos #(
   parameter int WIDTH = 32,
   parameter int POS_W = $clog2(WIDTH + 1)
) (
   input  wire logic [WIDTH-1:0] mask,
   output logic      [POS_W-1:0] pos
);

   logic [WIDTH:0] ext;
   logic [WIDTH:0] low_zero;

   // a zero above the top bit makes the all-ones case land on WIDTH
   assign ext      = {1'b0, mask};
   assign low_zero = ~ext & (ext + 1'b1);

   always_comb begin
      pos = '0;
      for (int j = 0; j <= WIDTH; j++) begin
         if (low_zero[j]) begin
            pos = pos | POS_W'(j);
         end
      end
   end

endmodule

`default_nettype wire
